>>> src/sync_header_packet_deframer_defines.svh
// Assertion macros for the packet deframer.
// Both expect clk and arst_n in the scope where they are used.
`ifndef SYNC_HEADER_PACKET_DEFRAMER_DEFINES_SVH
`define SYNC_HEADER_PACKET_DEFRAMER_DEFINES_SVH

// cond must never hold outside reset
`define SHPD_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

// ante implies cons in the same cycle
`define SHPD_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

>>> src/shpd_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// shpd_pkg
// Shared constants, types and address helper of the packet deframer.
// ---------------------------------------------------------------------------
package shpd_pkg;

	localparam int FULL_LENGTH  = 41;
	localparam int SHORT_LENGTH = 16;

	localparam logic [7:0] SYNC_BYTE = 8'hAA;
	localparam logic [7:0] HDR_BYTE2 = 8'h11;
	localparam logic [7:0] HDR_BYTE3 = 8'h01;
	localparam logic [7:0] HDR_BYTE4 = 8'hAC;

	localparam int CNT_W     = 6;
	localparam int BANKS     = 2;
	localparam int MEM_DEPTH = BANKS * FULL_LENGTH;
	localparam int ADDR_W    = $clog2(MEM_DEPTH);
	localparam int N_W       = $clog2(FULL_LENGTH + 1);

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} mem_wr_t;

	typedef struct packed {
		logic           err;
		logic           bank;
		logic [N_W-1:0] n;
	} job_t;

	function automatic logic [ADDR_W-1:0] bank_addr(input logic bank,
		input logic [CNT_W-1:0] idx);
		logic [ADDR_W-1:0] base;
		base = bank ? ADDR_W'(FULL_LENGTH) : '0;
		return base + ADDR_W'(idx);
	endfunction

endpackage

>>> src/shpd_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// shpd_front
// Header hunt, checksum and packet store writes; posts one job per packet.
// ---------------------------------------------------------------------------
module shpd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_wdata,
	input  logic              in_valid,
	input  logic [7:0]        in_byte,
	output logic              in_ready,
	input  logic              q_full,
	output logic              q_push,
	output shpd_pkg::job_t    q_job,
	output shpd_pkg::mem_wr_t mem_wr
);

	typedef enum logic [2:0] {
		HUNT,
		LEN,
		HB2,
		HB3,
		HB4,
		BODY
	} hdr_state_t;

	hdr_state_t                 state_q, state_n;
	logic [shpd_pkg::CNT_W-1:0] cnt_q, cnt_n;
	logic [7:0]                 sum_q, sum_n;
	logic                       bank_q, bank_n;
	logic                       short_mode_q;

	logic [7:0] pkt_len;
	logic [7:0] idx1;
	logic [7:0] sum_b;
	logic [7:0] expect_b;
	logic       accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign pkt_len  = short_mode_q ? 8'(shpd_pkg::SHORT_LENGTH) : 8'(shpd_pkg::FULL_LENGTH);
	assign idx1     = 8'(cnt_q) + 8'd1;
	assign sum_b    = sum_q + in_byte;

	always_comb begin
		state_n  = state_q;
		cnt_n    = cnt_q;
		sum_n    = sum_q;
		bank_n   = bank_q;
		q_push   = 1'b0;
		q_job    = '0;
		mem_wr   = '0;
		expect_b = pkt_len;
		unique case (state_q)
			HB2:     expect_b = shpd_pkg::HDR_BYTE2;
			HB3:     expect_b = shpd_pkg::HDR_BYTE3;
			HB4:     expect_b = shpd_pkg::HDR_BYTE4;
			default: expect_b = pkt_len;
		endcase
		if (accept) begin
			unique case (state_q)
				LEN, HB2, HB3, HB4: begin
					if (in_byte == expect_b) begin
						mem_wr.en   = 8'(cnt_q) < 8'(shpd_pkg::FULL_LENGTH);
						mem_wr.addr = shpd_pkg::bank_addr(bank_q, cnt_q);
						mem_wr.data = in_byte;
						cnt_n       = cnt_q + 1'b1;
						sum_n       = sum_b;
						state_n     = hdr_state_t'(state_q + 3'd1);
					end else begin
						state_n = HUNT;
						cnt_n   = '0;
						sum_n   = '0;
					end
				end
				BODY: begin
					mem_wr.en   = 8'(cnt_q) < 8'(shpd_pkg::FULL_LENGTH);
					mem_wr.addr = shpd_pkg::bank_addr(bank_q, cnt_q);
					mem_wr.data = in_byte;
					if (idx1 >= pkt_len) begin
						// final byte: post the packet or an error
						q_push     = 1'b1;
						q_job.err  = (sum_b != 8'd0);
						q_job.bank = bank_q;
						q_job.n    = (idx1 > 8'(shpd_pkg::FULL_LENGTH)) ?
							shpd_pkg::N_W'(shpd_pkg::FULL_LENGTH) : shpd_pkg::N_W'(idx1);
						if (sum_b == 8'd0)
							bank_n = !bank_q;
						state_n = HUNT;
						cnt_n   = '0;
						sum_n   = '0;
					end else begin
						cnt_n = cnt_q + 1'b1;
						sum_n = sum_b;
					end
				end
				default: begin
					state_n = HUNT;
					cnt_n   = '0;
					sum_n   = '0;
					if (in_byte == shpd_pkg::SYNC_BYTE) begin
						mem_wr.en   = 1'b1;
						mem_wr.addr = shpd_pkg::bank_addr(bank_q, '0);
						mem_wr.data = in_byte;
						cnt_n       = shpd_pkg::CNT_W'(1);
						sum_n       = in_byte;
						state_n     = LEN;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= HUNT;
			cnt_q        <= '0;
			sum_q        <= '0;
			bank_q       <= 1'b0;
			short_mode_q <= 1'b0;
		end else begin
			state_q <= state_n;
			cnt_q   <= cnt_n;
			sum_q   <= sum_n;
			bank_q  <= bank_n;
			if (cfg_we)
				short_mode_q <= cfg_wdata;
		end
	end

endmodule

>>> src/shpd_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// shpd_queue
// Two-entry job queue between the header front and the output back.
// ---------------------------------------------------------------------------
module shpd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  shpd_pkg::job_t push_job,
	input  logic           pop,
	output shpd_pkg::job_t head,
	output logic           full,
	output logic           empty
);

	shpd_pkg::job_t              entry_q [shpd_pkg::QUEUE_DEPTH];
	logic [shpd_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [shpd_pkg::QCNT_W-1:0] cnt_q;

	assign full  = (cnt_q == shpd_pkg::QCNT_W'(shpd_pkg::QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

>>> src/shpd_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// shpd_back
// Packet store and output sequencer: drains one job at a time.
// ---------------------------------------------------------------------------
module shpd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  shpd_pkg::mem_wr_t mem_wr,
	input  logic              q_empty,
	input  shpd_pkg::job_t    q_head,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              out_status,
	output logic [7:0]        out_data,
	output logic [5:0]        out_index,
	output logic              out_last
);

	typedef enum logic [1:0] {
		B_IDLE,
		B_READ,
		B_LOAD
	} back_state_t;

	logic [7:0] mem [shpd_pkg::MEM_DEPTH];
	logic [7:0] rd_data_q;
	logic       rd_en;

	back_state_t                state_q;
	logic [shpd_pkg::CNT_W-1:0] k_q;
	logic [shpd_pkg::N_W-1:0]   n_q;
	logic                       bank_q;
	logic                       out_valid_q;
	logic                       out_free;
	logic                       k_last;
	logic                       start;
	logic                       load_out;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign rd_en     = (state_q == B_READ);
	assign k_last    = (shpd_pkg::N_W'(k_q) == n_q - 1'b1);
	assign start     = (state_q == B_IDLE) && !q_empty && out_free;
	assign load_out  = (start && q_head.err) || ((state_q == B_LOAD) && out_free);
	// keep a good job queued until its last byte leaves the store, so the
	// front never refills the bank that is being read
	assign q_pop     = (start && q_head.err) || ((state_q == B_LOAD) && out_free && k_last);

	always_ff @(posedge clk) begin
		if (mem_wr.en)
			mem[mem_wr.addr] <= mem_wr.data;
		if (rd_en)
			rd_data_q <= mem[shpd_pkg::bank_addr(bank_q, k_q)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
			k_q         <= '0;
			n_q         <= '0;
			bank_q      <= 1'b0;
			out_status  <= 1'b0;
			out_data    <= '0;
			out_index   <= '0;
			out_last    <= 1'b0;
		end else begin
			out_valid_q <= load_out || (out_valid_q && !out_ready);
			unique case (state_q)
				B_IDLE: begin
					if (start) begin
						if (q_head.err) begin
							out_status <= 1'b1;
							out_data   <= '0;
							out_index  <= '0;
							out_last   <= 1'b1;
						end else begin
							k_q     <= '0;
							n_q     <= q_head.n;
							bank_q  <= q_head.bank;
							state_q <= B_READ;
						end
					end
				end
				B_READ: state_q <= B_LOAD;
				B_LOAD: begin
					// hold the read data until the output slot frees up
					if (out_free) begin
						out_status <= 1'b0;
						out_data   <= rd_data_q;
						out_index  <= k_q;
						out_last   <= k_last;
						if (k_last) begin
							state_q <= B_IDLE;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= B_READ;
						end
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

endmodule

>>> src/sync_header_packet_deframer.sv
`timescale 1ns / 1ps
// Input: one byte per cycle while the job queue has room; it fills only when two
//   packet jobs (good or error) are pending or draining.
// Output: each packet byte takes a store read, then an output register load; a good
//   packet's first byte passes the job queue, B_READ, B_LOAD and the output register
//   after its final byte is accepted, an error result the queue and the output register.
// Reset: asynchronous; clears hunt state, queue, sequencer and short_mode, not the store.
// ---------------------------------------------------------------------------
// sync_header_packet_deframer
// Sync-header packet deframer with two's complement checksum check.
// ---------------------------------------------------------------------------
`include "sync_header_packet_deframer_defines.svh"

module sync_header_packet_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,      // short_mode
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [7:0] data_byte, [13:8] byte_index, [15:14] zero
	output logic        m_axis_tuser,   // [0] status
	output logic        m_axis_tlast
);

	shpd_pkg::mem_wr_t mem_wr;
	shpd_pkg::job_t    push_job;
	shpd_pkg::job_t    q_head;
	logic              q_push, q_pop, q_full, q_empty;
	logic [7:0]        out_data;
	logic [5:0]        out_index;

	shpd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (s_axis_tvalid),
		.in_byte   (s_axis_tdata),
		.in_ready  (s_axis_tready),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_job     (push_job),
		.mem_wr    (mem_wr)
	);

	shpd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (push_job),
		.pop      (q_pop),
		.head     (q_head),
		.full     (q_full),
		.empty    (q_empty)
	);

	shpd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.mem_wr     (mem_wr),
		.q_empty    (q_empty),
		.q_head     (q_head),
		.q_pop      (q_pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_status (m_axis_tuser),
		.out_data   (out_data),
		.out_index  (out_index),
		.out_last   (m_axis_tlast)
	);

	assign m_axis_tdata = {2'b00, out_index, out_data};

	`SHPD_ASSERT_NEVER(a_queue_overflow, q_push && q_full, "job pushed into full queue")
	`SHPD_ASSERT_NEVER(a_queue_underflow, q_pop && q_empty, "job popped from empty queue")
	`SHPD_ASSERT_IMPLY(a_error_result, m_axis_tvalid && m_axis_tuser, m_axis_tlast && (m_axis_tdata == 16'd0), "error result not a lone zero item")

endmodule

>>> test/shpd_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// shpd_checker
// Follows the header hunt and packet store of the deframer from the
// accepted input bytes and the short_mode writes. It predicts every output
// beat and compares the accepted beats with those predictions in order.
// ---------------------------------------------------------------------------
module shpd_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [15:0] m_axis_tdata,
	input  logic        m_axis_tuser,
	input  logic        m_axis_tlast,
	output int          mismatches,
	output int          outstanding
);

	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_BAD = 1'b1;

	localparam logic [2:0] POS_HUNT = 3'd0;
	localparam logic [2:0] POS_LEN  = 3'd1;
	localparam logic [2:0] POS_HDR2 = 3'd2;
	localparam logic [2:0] POS_HDR3 = 3'd3;
	localparam logic [2:0] POS_HDR4 = 3'd4;
	localparam logic [2:0] POS_BODY = 3'd5;

	typedef struct packed {
		logic       status;
		logic [7:0] data_byte;
		logic [5:0] byte_index;
		logic       last;
	} deframed_beat_t;

	deframed_beat_t beats_due[$];
	deframed_beat_t seen_beat;
	deframed_beat_t due_beat;

	logic       short_mode_q;
	logic [2:0] hdr_pos;
	logic [5:0] byte_cnt;
	logic [7:0] run_sum;
	logic [7:0] pkt_mem [shpd_pkg::FULL_LENGTH];
	int         bad_count;

	task automatic restart_hunt();
		hdr_pos  = POS_HUNT;
		byte_cnt = '0;
		run_sum  = '0;
	endtask

	task automatic keep_byte(input logic [7:0] b);
		if (byte_cnt < shpd_pkg::FULL_LENGTH)
			pkt_mem[byte_cnt] = b;
		byte_cnt = byte_cnt + 6'd1;
		run_sum  = run_sum + b;
	endtask

	task automatic deframe_byte(input logic [7:0] b);
		int unsigned    plen;
		int unsigned    n;
		logic [7:0]     want;
		logic [7:0]     total;
		deframed_beat_t beat;
		plen = short_mode_q ? shpd_pkg::SHORT_LENGTH : shpd_pkg::FULL_LENGTH;
		case (hdr_pos)
			POS_LEN, POS_HDR2, POS_HDR3, POS_HDR4: begin
				case (hdr_pos)
					POS_LEN:  want = 8'(plen);
					POS_HDR2: want = shpd_pkg::HDR_BYTE2;
					POS_HDR3: want = shpd_pkg::HDR_BYTE3;
					default:  want = shpd_pkg::HDR_BYTE4;
				endcase
				// a mismatching byte is dropped, never taken as a new sync byte
				if (b == want) begin
					keep_byte(b);
					hdr_pos = hdr_pos + 3'd1;
				end else begin
					restart_hunt();
				end
			end
			POS_BODY: begin
				// length follows short_mode at every byte
				if (int'(byte_cnt) + 1 >= plen) begin
					if (byte_cnt < shpd_pkg::FULL_LENGTH)
						pkt_mem[byte_cnt] = b;
					total = run_sum + b;
					if (total != 8'd0) begin
						beat.status     = STATUS_BAD;
						beat.data_byte  = 8'd0;
						beat.byte_index = 6'd0;
						beat.last       = 1'b1;
						beats_due.push_back(beat);
					end else begin
						n = int'(byte_cnt) + 1;
						if (n > shpd_pkg::FULL_LENGTH)
							n = shpd_pkg::FULL_LENGTH;
						for (int k = 0; k < n; k++) begin
							beat.status     = STATUS_OK;
							beat.data_byte  = pkt_mem[k];
							beat.byte_index = 6'(k);
							beat.last       = (k + 1 == n);
							beats_due.push_back(beat);
						end
					end
					restart_hunt();
				end else begin
					keep_byte(b);
				end
			end
			default: begin
				// hunting, and any position out of range
				restart_hunt();
				if (b == shpd_pkg::SYNC_BYTE) begin
					keep_byte(b);
					hdr_pos = POS_LEN;
				end
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_mode_q = 1'b0;
			restart_hunt();
			beats_due.delete();
			bad_count = 0;
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				seen_beat.status     = m_axis_tuser;
				seen_beat.data_byte  = m_axis_tdata[7:0];
				seen_beat.byte_index = m_axis_tdata[13:8];
				seen_beat.last       = m_axis_tlast;
				if (beats_due.size() == 0) begin
					if (bad_count < 10)
						$display("unexpected beat: status %0d data %02h index %0d last %0d",
							seen_beat.status, seen_beat.data_byte, seen_beat.byte_index,
							seen_beat.last);
					bad_count++;
				end else begin
					due_beat = beats_due.pop_front();
					if (seen_beat != due_beat || m_axis_tdata[15:14] != 2'b00) begin
						if (bad_count < 10)
							$display({"beat mismatch: expected status %0d data %02h index %0d",
								" last %0d, got status %0d data %02h index %0d last %0d pad %0d"},
								due_beat.status, due_beat.data_byte, due_beat.byte_index,
								due_beat.last, seen_beat.status, seen_beat.data_byte,
								seen_beat.byte_index, seen_beat.last, m_axis_tdata[15:14]);
						bad_count++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				deframe_byte(s_axis_tdata);
			if (cfg_we)
				short_mode_q = cfg_wdata;
			mismatches  <= bad_count;
			outstanding <= beats_due.size();
		end
	end

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Feeds the deframer with noise, broken headers, good and bad packets and
// packets that change length mode halfway, in bursts against a receiver
// that stalls, and reports the verdict from the checker's mismatch and outstanding counts.
// ---------------------------------------------------------------------------
module testbench;

	localparam int CYCLE_LIMIT   = 500000;
	localparam int SETTLE_CYCLES = 16;
	localparam int TAIL_CYCLES   = 40;
	localparam int HOLD_CYCLES   = 800;
	localparam int ITEM_TARGET   = 470;

	typedef enum int {
		RX_OPEN,
		RX_COIN,
		RX_MOSTLY,
		RX_PERIODIC,
		RX_SPARSE
	} rx_style_e;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        cfg_we        = 1'b0;
	logic        cfg_wdata     = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic [7:0]  s_axis_tdata  = 8'd0;
	logic        m_axis_tready = 1'b0;
	wire         s_axis_tready;
	wire         m_axis_tvalid;
	wire  [15:0] m_axis_tdata;
	wire         m_axis_tuser;
	wire         m_axis_tlast;

	int          mismatches;
	int          outstanding;
	int          cycle_count  = 0;
	logic        cur_mode     = 1'b0;
	logic [7:0]  frame_sum    = 8'd0;
	int          burst_left   = 0;
	int          sent_bytes   = 0;
	logic        hold_trigger = 1'b0;
	logic        hold_seen    = 1'b0;
	int          hold_left    = 0;
	rx_style_e   rx_style     = RX_OPEN;
	int          style_left   = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	sync_header_packet_deframer u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	shpd_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.mismatches    (mismatches),
		.outstanding   (outstanding)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	// receiver: long hold on request, otherwise a changing stall pattern
	always @(posedge clk) begin
		if (hold_left != 0) begin
			m_axis_tready <= 1'b0;
			hold_left     <= hold_left - 1;
		end else if (hold_trigger != hold_seen) begin
			hold_seen     <= hold_trigger;
			hold_left     <= HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else begin
			if (style_left == 0) begin
				rx_style   <= rx_style_e'($urandom_range(0, 4));
				style_left <= $urandom_range(20, 120);
			end else begin
				style_left <= style_left - 1;
			end
			case (rx_style)
				RX_OPEN:     m_axis_tready <= 1'b1;
				RX_COIN:     m_axis_tready <= 1'($urandom_range(0, 1));
				RX_MOSTLY:   m_axis_tready <= ($urandom_range(0, 3) != 0);
				RX_PERIODIC: m_axis_tready <= (cycle_count % 7 < 3);
				default:     m_axis_tready <= ($urandom_range(0, 4) == 0);
			endcase
		end
	end

	function automatic int pkt_len(input logic m);
		return m ? shpd_pkg::SHORT_LENGTH : shpd_pkg::FULL_LENGTH;
	endfunction

	// offer one byte, in bursts with random gaps, and hold it until accepted
	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 40) : $urandom_range(0, 4);
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 5) == 0) ? 64 : $urandom_range(1, 12);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		frame_sum = frame_sum + b;
		sent_bytes++;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		burst_left--;
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	task automatic write_mode(input logic m);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_mode = m;
	endtask

	task automatic send_header(input logic [7:0] len_byte);
		frame_sum = 8'd0;
		send_byte(shpd_pkg::SYNC_BYTE);
		send_byte(len_byte);
		send_byte(shpd_pkg::HDR_BYTE2);
		send_byte(shpd_pkg::HDR_BYTE3);
		send_byte(shpd_pkg::HDR_BYTE4);
	endtask

	// fill below zero means random content
	task automatic send_body(input int count, input int fill);
		for (int i = 0; i < count; i++)
			send_byte((fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill));
	endtask

	task automatic send_check(input bit good);
		logic [7:0] fix;
		fix = 8'd0 - frame_sum;
		if (!good)
			fix = fix + 8'($urandom_range(1, 255));
		send_byte(fix);
	endtask

	task automatic send_packet(input bit good, input int fill);
		send_header(8'(pkt_len(cur_mode)));
		send_body(pkt_len(cur_mode) - 6, fill);
		send_check(good);
	endtask

	// flip the length mode after k body bytes, then finish by the new length
	task automatic send_split(input int k, input bit good);
		int rest;
		send_header(8'(pkt_len(cur_mode)));
		send_body(k, -1);
		write_mode(!cur_mode);
		rest = pkt_len(cur_mode) - 6 - k;
		send_body((rest < 0) ? 0 : rest, -1);
		send_check(good);
	endtask

	// header correct up to pos, then a wrong byte there
	task automatic send_broken(input int pos, input logic [7:0] wrong);
		logic [7:0] hdr [5];
		hdr[0] = shpd_pkg::SYNC_BYTE;
		hdr[1] = 8'(pkt_len(cur_mode));
		hdr[2] = shpd_pkg::HDR_BYTE2;
		hdr[3] = shpd_pkg::HDR_BYTE3;
		hdr[4] = shpd_pkg::HDR_BYTE4;
		for (int i = 0; i < pos; i++)
			send_byte(hdr[i]);
		send_byte((wrong == hdr[pos]) ? ~wrong : wrong);
	endtask

	task automatic send_noise(input int count);
		for (int i = 0; i < count; i++)
			send_byte(($urandom_range(0, 9) == 0) ? shpd_pkg::SYNC_BYTE :
				8'($urandom_range(0, 255)));
	endtask

	// hold the receiver off and keep sending until the input stalls
	task automatic stuff_while_held();
		hold_trigger <= ~hold_trigger;
		repeat (4) send_packet(1'b1, -1);
	endtask

	initial begin
		int pick;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// bytes while hunting
		send_byte(8'h00);
		send_byte(8'hFF);
		// repeated sync byte is dropped; the rest of the header is then ignored
		send_broken(1, shpd_pkg::SYNC_BYTE);
		send_byte(8'(shpd_pkg::FULL_LENGTH));
		send_byte(shpd_pkg::HDR_BYTE2);
		send_byte(shpd_pkg::HDR_BYTE3);
		send_byte(shpd_pkg::HDR_BYTE4);
		send_broken(1, 8'(shpd_pkg::SHORT_LENGTH));
		send_broken(2, 8'h00);
		send_broken(3, 8'hFF);
		send_broken(4, 8'hAD);

		send_packet(1'b1, 8'h00);
		send_packet(1'b0, 8'hFF);
		write_mode(1'b1);
		send_packet(1'b1, 8'hFF);
		send_packet(1'b0, -1);
		send_packet(1'b1, -1);

		// length mode changes inside a packet
		send_split(0, 1'b1);
		send_split(shpd_pkg::FULL_LENGTH - 6, 1'b1);
		write_mode(1'b0);
		send_split(3, 1'b1);

		stuff_while_held();
		wait_drained();

		while (sent_bytes < ITEM_TARGET) begin
			pick = $urandom_range(0, 99);
			if (pick < 40)
				send_packet(1'b1, -1);
			else if (pick < 52)
				send_packet(1'b0, -1);
			else if (pick < 64)
				send_broken($urandom_range(1, 4),
					($urandom_range(0, 3) == 0) ? shpd_pkg::SYNC_BYTE :
					8'($urandom_range(0, 255)));
			else if (pick < 74)
				send_noise($urandom_range(1, 8));
			else if (pick < 86)
				write_mode($urandom_range(0, 3) != 0);
			else if (pick < 96)
				send_split($urandom_range(0, pkt_len(cur_mode) - 6), $urandom_range(0, 3) != 0);
			else
				stuff_while_held();
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
